/* design/csd_pkg.sv */
// Package for the command stream decoder: kind codes, command ids,
// queue sizing and the item/result structs shared by all design files.
// No dependencies.
`default_nettype none

package csd_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    K_CFG     = 3'd0,
    K_WRITE   = 3'd1,
    K_SYNC    = 3'd2,
    K_NEXT    = 3'd3,
    K_UNKNOWN = 3'd4,
    K_IGNORED = 3'd5
  } kind_t;

  // Command ids in bits 30:28
  localparam logic [2:0] ID_CFG  = 3'd1;
  localparam logic [2:0] ID_SYNC = 3'd6;
  localparam logic [2:0] ID_NEXT = 3'd7;

  // Field widths
  localparam int WORD_W  = 32;
  localparam int ADDR_W  = 17;
  localparam int COUNT_W = 12;

  // Register address stride in bytes
  localparam logic [ADDR_W-1:0] ADDR_STEP = 17'd4;

  // Front-to-back queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Classified item handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic [WORD_W-1:0]  word;
    logic [ADDR_W-1:0]  addr;
    logic               last;
    logic               fin;
  } item_t;

  // Queue status seen by the back end and the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Formatted result
  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  reg_address;
    logic [WORD_W-1:0]  reg_data;
    logic [COUNT_W-1:0] write_count;
    logic [3:0]         sync_op;
    logic [15:0]        sync_mask;
    logic [7:0]         reserved_bits;
    logic [23:0]        next_pointer;
    logic               command_last;
    logic               final_write;
    logic [2:0]         unknown_id;
  } result_t;

endpackage

`default_nettype wire

/* design/csd_front.sv */
// Front end of the command stream decoder: tracks payload/stop state and
// classifies each accepted beat into an item_t. Depends on csd_pkg.
`default_nettype none

module csd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc,
  input  wire logic [31:0]   word,
  input  wire logic          buffer_start,
  output csd_pkg::item_t     item
);
  import csd_pkg::*;

  logic               in_payload_r, in_payload_nxt;
  logic [COUNT_W-1:0] words_left_r, words_left_nxt;
  logic [ADDR_W-1:0]  write_address_r, write_address_nxt;
  logic               header_last_r, header_last_nxt;
  logic               stopped_r, stopped_nxt;

  logic               eff_payload;
  logic               eff_stopped;
  logic [2:0]         id;
  logic [COUNT_W-1:0] rn;

  assign eff_payload = in_payload_r & ~buffer_start;
  assign eff_stopped = stopped_r & ~buffer_start;
  assign id          = word[30:28];
  assign rn          = word[27:16];

  // Classify the beat and compute next state
  always_comb begin
    item.kind         = K_IGNORED;
    item.word         = word;
    item.addr         = write_address_r;
    item.last         = word[31];
    item.fin          = 1'b0;
    in_payload_nxt    = eff_payload;
    words_left_nxt    = buffer_start ? '0 : words_left_r;
    write_address_nxt = write_address_r;
    header_last_nxt   = header_last_r;
    stopped_nxt       = eff_stopped;
    if (eff_stopped) begin
      item.kind = K_IGNORED;
    end else if (eff_payload) begin
      item.kind         = K_WRITE;
      item.last         = header_last_r;
      item.fin          = (words_left_r == COUNT_W'(1));
      write_address_nxt = write_address_r + ADDR_STEP;
      words_left_nxt    = words_left_r - COUNT_W'(1);
      if (words_left_r == COUNT_W'(1)) begin
        in_payload_nxt = 1'b0;
      end
    end else begin
      case (id)
        ID_CFG: begin
          item.kind = K_CFG;
          if (rn != '0) begin
            in_payload_nxt    = 1'b1;
            words_left_nxt    = rn;
            write_address_nxt = {1'b0, word[15:0]};
            header_last_nxt   = word[31];
          end
        end
        ID_SYNC: item.kind = K_SYNC;
        ID_NEXT: item.kind = K_NEXT;
        default: begin
          item.kind   = K_UNKNOWN;
          stopped_nxt = 1'b1;
        end
      endcase
    end
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r    <= 1'b0;
      words_left_r    <= '0;
      write_address_r <= '0;
      header_last_r   <= 1'b0;
      stopped_r       <= 1'b0;
    end else if (acc) begin
      in_payload_r    <= in_payload_nxt;
      words_left_r    <= words_left_nxt;
      write_address_r <= write_address_nxt;
      header_last_r   <= header_last_nxt;
      stopped_r       <= stopped_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/csd_queue.sv */
// Short flop queue between the decoder front and back ends.
// Depends on csd_pkg for item_t and queue sizing.
`default_nettype none

module csd_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr,
  input  csd_pkg::item_t   wr_item,
  input  wire logic        rd,
  output csd_pkg::item_t   rd_item,
  output csd_pkg::q_stat_t stat
);
  import csd_pkg::*;

  item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_wr      = wr & ~stat.full;
  assign do_rd      = rd & ~stat.empty;
  assign rd_item    = slot_r[rp_r];

  // Pointer and count updates
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + QPTR_W'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + QPTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the beat; slots need no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

/* design/csd_back.sv */
// Back end of the command stream decoder: formats queued items into result
// fields and holds them in the output register. Depends on csd_pkg.
`default_nettype none

module csd_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  csd_pkg::item_t   item,
  input  csd_pkg::q_stat_t qstat,
  output logic             q_rd,
  input  wire logic        pop,
  output logic             empty,
  output csd_pkg::result_t res
);
  import csd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;
  logic    load;

  assign load  = ~qstat.empty & (~valid_r | pop);
  assign q_rd  = load;
  assign empty = ~valid_r;
  assign res   = res_r;

  // Format fields by kind; fields that do not apply stay zero
  always_comb begin
    res_nxt      = '0;
    res_nxt.kind = item.kind;
    case (item.kind)
      K_CFG: begin
        res_nxt.reg_address  = {1'b0, item.word[15:0]};
        res_nxt.write_count  = item.word[27:16];
        res_nxt.command_last = item.last;
      end
      K_WRITE: begin
        res_nxt.reg_address  = item.addr;
        res_nxt.reg_data     = item.word;
        res_nxt.command_last = item.last;
        res_nxt.final_write  = item.fin;
      end
      K_SYNC: begin
        res_nxt.sync_op       = item.word[27:24];
        res_nxt.sync_mask     = item.word[15:0];
        res_nxt.reserved_bits = item.word[23:16];
        res_nxt.command_last  = item.last;
      end
      K_NEXT: begin
        res_nxt.reserved_bits = {4'b0, item.word[27:24]};
        res_nxt.next_pointer  = item.word[23:0];
        res_nxt.command_last  = item.last;
      end
      K_UNKNOWN: begin
        res_nxt.unknown_id = item.word[30:28];
      end
      default: begin
        res_nxt.kind = K_IGNORED;
      end
    endcase
  end

  // Output valid: load from queue, drop on pop
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/command_stream_decoder_core.sv */
// Command stream decoder top level: front classifier, two-beat queue, back formatter.
// An accepted beat enters a queue slot, then the output register once that is free.
// Throughput: one beat per cycle while in_full is low; front classify is combinational.
// The two-entry queue and output register absorb stalls; in_full means the queue is full.
// Reset (rst_n low, synchronous) clears decode state, queue and output valid.
// Depends on csd_pkg, csd_front, csd_queue, csd_back.
`default_nettype none

module command_stream_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [31:0] in_word,
  input  wire logic        in_buffer_start,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [2:0]       out_kind,
  output logic [16:0]      out_reg_address,
  output logic [31:0]      out_reg_data,
  output logic [11:0]      out_write_count,
  output logic [3:0]       out_sync_op,
  output logic [15:0]      out_sync_mask,
  output logic [7:0]       out_reserved_bits,
  output logic [23:0]      out_next_pointer,
  output logic             out_command_last,
  output logic             out_final_write,
  output logic [2:0]       out_unknown_id
);
  import csd_pkg::*;

  item_t   fr_item;
  item_t   q_item;
  q_stat_t q_stat;
  logic    q_rd;
  logic    in_acc;
  result_t res;

  assign in_full = q_stat.full;
  assign in_acc  = in_push & ~q_stat.full;

  csd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .word         (in_word),
    .buffer_start (in_buffer_start),
    .item         (fr_item)
  );

  csd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (in_acc),
    .wr_item (fr_item),
    .rd      (q_rd),
    .rd_item (q_item),
    .stat    (q_stat)
  );

  csd_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (q_item),
    .qstat (q_stat),
    .q_rd  (q_rd),
    .pop   (out_pop),
    .empty (out_empty),
    .res   (res)
  );

  // Unpack the result onto the ports
  assign out_kind          = res.kind;
  assign out_reg_address   = res.reg_address;
  assign out_reg_data      = res.reg_data;
  assign out_write_count   = res.write_count;
  assign out_sync_op       = res.sync_op;
  assign out_sync_mask     = res.sync_mask;
  assign out_reserved_bits = res.reserved_bits;
  assign out_next_pointer  = res.next_pointer;
  assign out_command_last  = res.command_last;
  assign out_final_write   = res.final_write;
  assign out_unknown_id    = res.unknown_id;

  // Only register writes carry data or the burst end flag
  a_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind != K_WRITE) |-> (out_reg_data == '0 && !out_final_write))
    else $error("data or final flag on a non-write result");

  // Only an unknown stop reports an id
  a_unknown_id: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind != K_UNKNOWN) |-> (out_unknown_id == '0))
    else $error("unknown id on a result that is not a stop");

  // A buffer start always decodes as a fresh command
  a_start_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_buffer_start) |-> (fr_item.kind != K_IGNORED && fr_item.kind != K_WRITE))
    else $error("buffer start beat not decoded as a command");

endmodule

`default_nettype wire
